@@ rtl/u8dw_pkg.sv @@
// ----------------------------------------------------------------------------
// u8dw_pkg
// Shared types, constants and the column lookup for the UTF-8 display width
// counter.
// ----------------------------------------------------------------------------
package u8dw_pkg;

  // Running total width and reported width
  localparam int WidthBits = 16;
  localparam int OutBits   = 16;
  localparam int CpBits    = 21;

  // Largest amount one byte can add: three held bytes plus one for the byte itself
  localparam int AddBits   = 3;

  // Control bytes that end counting
  localparam logic [7:0] ByteLf = 8'h0A;
  localparam logic [7:0] ByteCr = 8'h0D;

  // Sequence lengths announced by a lead byte
  localparam logic [2:0] SeqLen2 = 3'd2;
  localparam logic [2:0] SeqLen3 = 3'd3;
  localparam logic [2:0] SeqLen4 = 3'd4;

  // Decoder state carried from byte to byte
  typedef struct packed {
    logic [1:0]        held;
    logic [2:0]        seq_len;
    logic [CpBits-1:0] cp;
    logic              brk;
  } seq_state_t;

  // Result of decoding one byte
  typedef struct packed {
    seq_state_t         state;
    logic [AddBits-1:0] add;
  } step_t;

  // Terminal columns of one code point: 0, 1 or 2
  function automatic logic [1:0] columns_of(input logic [CpBits-1:0] cp);
    logic zero;
    logic wide;
    zero = (cp == 21'h0200B) || (cp == 21'h0200C) || (cp == 21'h0200D) ||
           (cp == 21'h0FEFF) ||
           (cp >= 21'h00300 && cp <= 21'h0036F) ||
           (cp >= 21'h01AB0 && cp <= 21'h01AFF) ||
           (cp >= 21'h01DC0 && cp <= 21'h01DFF) ||
           (cp >= 21'h020D0 && cp <= 21'h020FF) ||
           (cp >= 21'h0FE00 && cp <= 21'h0FE0F) ||
           (cp >= 21'h0FE20 && cp <= 21'h0FE2F) ||
           (cp >= 21'hE0100 && cp <= 21'hE01EF);
    wide = (cp >= 21'h01100 && cp <= 21'h0115F) ||
           (cp >= 21'h02329 && cp <= 21'h0232A) ||
           (cp >= 21'h02E80 && cp <= 21'h0A4CF) ||
           (cp >= 21'h0AC00 && cp <= 21'h0D7A3) ||
           (cp >= 21'h0F900 && cp <= 21'h0FAFF) ||
           (cp >= 21'h0FE10 && cp <= 21'h0FE19) ||
           (cp >= 21'h0FE30 && cp <= 21'h0FE6F) ||
           (cp >= 21'h0FF00 && cp <= 21'h0FF60) ||
           (cp >= 21'h0FFE0 && cp <= 21'h0FFE6) ||
           (cp >= 21'h1F300 && cp <= 21'h1F9FF) ||
           (cp >= 21'h20000 && cp <= 21'h3FFFD);
    if (zero) begin
      return 2'd0;
    end else if (wide) begin
      return 2'd2;
    end else begin
      return 2'd1;
    end
  endfunction

  // Saturating add of one byte's columns to the running total
  function automatic logic [WidthBits-1:0] sat_add(input logic [WidthBits-1:0] total,
                                                   input logic [AddBits-1:0] add);
    logic [WidthBits:0] sum;
    sum = {1'b0, total} + (WidthBits+1)'(add);
    if (sum[WidthBits]) begin
      return {WidthBits{1'b1}};
    end else begin
      return sum[WidthBits-1:0];
    end
  endfunction

  // Clamp the running total to the reported width
  function automatic logic [OutBits-1:0] clamp_out(input logic [WidthBits-1:0] total);
    logic [32:0] wide;
    wide = 33'(total);
    if (wide > 33'({OutBits{1'b1}})) begin
      return {OutBits{1'b1}};
    end else begin
      return wide[OutBits-1:0];
    end
  endfunction

endpackage

@@ rtl/u8dw_decode.sv @@
// ----------------------------------------------------------------------------
// u8dw_decode
// Combinational UTF-8 step: takes the held sequence state and one byte and
// gives the next state and the columns the byte adds.
// ----------------------------------------------------------------------------
module u8dw_decode (
  input  u8dw_pkg::seq_state_t state,
  input  logic [7:0]           text_byte,
  input  logic                 final_byte,
  output u8dw_pkg::step_t      step
);

  logic                               cont;
  logic [2:0]                         n;
  logic [u8dw_pkg::CpBits-1:0]        cp_ext;
  u8dw_pkg::seq_state_t               nxt;
  logic [u8dw_pkg::AddBits-1:0]       add;

  assign cont   = (text_byte[7:6] == 2'b10);
  assign n      = {1'b0, state.held} + 3'd1;
  assign cp_ext = {state.cp[u8dw_pkg::CpBits-7:0], text_byte[5:0]};

  // Sequence handling, then lead handling
  always_comb begin
    nxt = state;
    add = '0;
    if (state.brk) begin
      // counting stopped; bytes ignored until the final one
    end else if (state.held != 2'd0 && cont) begin
      nxt.cp = cp_ext;
      if (n >= state.seq_len) begin
        add      = u8dw_pkg::AddBits'(u8dw_pkg::columns_of(cp_ext));
        nxt.held = 2'd0;
      end else if (final_byte) begin
        add      = n;
        nxt.held = 2'd0;
      end else begin
        nxt.held = n[1:0];
      end
    end else begin
      // no sequence open, or a broken one: each held byte counts one, byte read as a lead
      add      = u8dw_pkg::AddBits'(state.held);
      nxt.held = 2'd0;
      if (text_byte == u8dw_pkg::ByteLf || text_byte == u8dw_pkg::ByteCr) begin
        nxt.brk = 1'b1;
      end else if (text_byte[7:5] == 3'b110) begin
        nxt.seq_len = u8dw_pkg::SeqLen2;
        nxt.held    = 2'd1;
        nxt.cp      = u8dw_pkg::CpBits'(text_byte[4:0]);
      end else if (text_byte[7:4] == 4'b1110) begin
        nxt.seq_len = u8dw_pkg::SeqLen3;
        nxt.held    = 2'd1;
        nxt.cp      = u8dw_pkg::CpBits'(text_byte[3:0]);
      end else if (text_byte[7:3] == 5'b11110) begin
        nxt.seq_len = u8dw_pkg::SeqLen4;
        nxt.held    = 2'd1;
        nxt.cp      = u8dw_pkg::CpBits'(text_byte[2:0]);
      end else begin
        // ASCII, stray continuation or F8-FF: none of these is zero-width or wide
        add = add + u8dw_pkg::AddBits'(1);
      end
    end

    // Sequence cut short by the final byte: each held byte counts one
    if (final_byte) begin
      add = add + u8dw_pkg::AddBits'(nxt.held);
      nxt = '0;
    end
  end

  assign step.state = nxt;
  assign step.add   = add;

endmodule

@@ rtl/utf8_display_width_counter.sv @@
// ----------------------------------------------------------------------------
// utf8_display_width_counter
// Counts the terminal columns of a UTF-8 string, one byte per transfer, and
// reports the saturated total on the final byte.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+--------------------------------
//  in      | in_valid / in_ready | text_byte[7:0], final_byte
//  out     | out_valid/out_ready | display_width[15:0]
//
//  One byte per cycle sustained while no final byte waits on a held result;
//  a byte passes the input register, then decode into state and result
//  register. Rate is set by the single decode step between the input
//  register and the sequence state registers.
//  Reset (synchronous, rst high) empties both registers and clears the state.
//  A result held on out stalls only final bytes; other bytes keep flowing.
// ----------------------------------------------------------------------------
module utf8_display_width_counter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  text_byte,
  input  logic        final_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] display_width
);

  // Input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_fin;
  logic       advance;

  // Sequence state and running total
  u8dw_pkg::seq_state_t                 state;
  logic [u8dw_pkg::WidthBits-1:0]       total;
  logic [u8dw_pkg::WidthBits-1:0]       total_next;
  u8dw_pkg::step_t                      step;

  // A non-final byte never needs the result register
  assign advance  = s1_valid && (!s1_fin || !out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte <= text_byte;
      s1_fin  <= final_byte;
    end
  end

  // Decode step
  u8dw_decode u_decode (
    .state      (state),
    .text_byte  (s1_byte),
    .final_byte (s1_fin),
    .step       (step)
  );

  assign total_next = u8dw_pkg::sat_add(total, step.add);

  // State update; a final byte returns everything to the reset state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
      total <= '0;
    end else if (advance) begin
      state <= step.state;
      total <= s1_fin ? '0 : total_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && s1_fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_fin) begin
      display_width <= u8dw_pkg::clamp_out(total_next);
    end
  end

  // Checks
  a_held_in_range: assert property (@(posedge clk) disable iff (rst)
    state.held != 2'd0 |-> state.seq_len > 3'(state.held) && state.seq_len <= 3'd4)
    else $error("held byte count not below announced sequence length");

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    advance && s1_fin |=> state == '0 && total == '0)
    else $error("state not cleared after final byte");

  a_break_sticks: assert property (@(posedge clk) disable iff (rst)
    state.brk && !(advance && s1_fin) |=> state.brk)
    else $error("line break flag dropped before final byte");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(advance && s1_fin))
    else $error("result raised without a final byte");

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for utf8_display_width_counter. Strings of bytes go in
// over the valid/ready input with random gaps. An in-bench width model follows
// every accepted byte and queues the total due on each final byte. Results are
// checked in order against that queue. A short table of hand-picked strings
// comes first, then random strings that are mostly well formed UTF-8 with
// broken, truncated and stray bytes mixed in.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int QuietLimit  = 2000;  // cycles with no transfer before giving up
  localparam int HoldCycles  = 400;   // long receiver hold-off
  localparam int RandomBytes = 1080;
  localparam int DirRows     = 26;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  text_byte;
  logic        final_byte;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] display_width;

  // Hand-typed total travelling alongside the payload, used on final bytes
  logic        tag_typed;
  logic [15:0] tag_want;

  logic        tx_idle_on;
  logic        rx_idle_on;
  logic        hold_req;
  int          errors;
  int          quiet_cycles;

  logic [15:0] pending_widths[$];
  logic [7:0]  str_q[$];

  // Width model state
  logic [1:0]  held_cnt;
  logic [2:0]  seq_need;
  logic [20:0] cp_acc;
  logic [15:0] col_total;
  logic        stopped;

  // Directed strings: bytes from the top, length, typed total if any
  typedef struct packed {
    logic [47:0] seq;
    logic [2:0]  len;
    logic        typed;
    logic [15:0] want;
  } probe_row_t;

  probe_row_t dir_tab [DirRows] = '{
    '{48'h41_00_00_00_00_00, 3'd1, 1'b1, 16'd1},  // plain ASCII
    '{48'h00_00_00_00_00_00, 3'd1, 1'b1, 16'd1},  // lowest byte
    '{48'h7F_00_00_00_00_00, 3'd1, 1'b1, 16'd1},  // top of ASCII
    '{48'hFF_00_00_00_00_00, 3'd1, 1'b1, 16'd1},  // stray high byte
    '{48'h0A_00_00_00_00_00, 3'd1, 1'b1, 16'd0},  // LF straight away
    '{48'h41_0D_42_00_00_00, 3'd3, 1'b1, 16'd1},  // CR stops counting
    '{48'hC3_A9_00_00_00_00, 3'd2, 1'b0, 16'd0},  // two-byte form
    '{48'hE3_81_82_00_00_00, 3'd3, 1'b0, 16'd0},  // wide, three-byte
    '{48'hF0_9F_98_80_00_00, 3'd4, 1'b0, 16'd0},  // wide, four-byte
    '{48'h65_CC_81_00_00_00, 3'd3, 1'b0, 16'd0},  // combining accent
    '{48'hE2_80_8D_00_00_00, 3'd3, 1'b0, 16'd0},  // zero width joiner
    '{48'hEF_BB_BF_00_00_00, 3'd3, 1'b0, 16'd0},  // byte order mark
    '{48'hC3_41_00_00_00_00, 3'd2, 1'b1, 16'd2},  // broken by ASCII
    '{48'hE3_81_00_00_00_00, 3'd2, 1'b1, 16'd2},  // cut short on continuation
    '{48'hE3_00_00_00_00_00, 3'd1, 1'b1, 16'd1},  // cut short on lead
    '{48'h80_BF_00_00_00_00, 3'd2, 1'b1, 16'd2},  // stray continuations
    '{48'hF7_BF_BF_BF_00_00, 3'd4, 1'b0, 16'd0},  // highest code point
    '{48'hC0_80_00_00_00_00, 3'd2, 1'b0, 16'd0},  // overlong zero
    '{48'hC0_0A_41_00_00_00, 3'd3, 1'b1, 16'd1},  // broken by LF
    '{48'h0A_E3_81_00_00_00, 3'd3, 1'b1, 16'd0},  // sequence after a break
    '{48'hF8_FE_00_00_00_00, 3'd2, 1'b1, 16'd2},  // invalid leads
    '{48'hEA_B0_80_00_00_00, 3'd3, 1'b0, 16'd0},  // Hangul start
    '{48'hF0_A0_80_80_00_00, 3'd4, 1'b0, 16'd0},  // wide plane two
    '{48'hF3_A0_84_80_00_00, 3'd4, 1'b0, 16'd0},  // variation selector
    '{48'hE3_C3_A9_00_00_00, 3'd3, 1'b0, 16'd0},  // broken by a new lead
    '{48'hF4_80_41_C3_A9_7E, 3'd6, 1'b1, 16'd5}   // two held, then more text
  };

  // Ends of every zero and wide range, for boundary code points
  logic [20:0] span_ends [39] = '{
    21'h0200B, 21'h0200D, 21'h0FEFF, 21'h00300, 21'h0036F, 21'h01AB0, 21'h01AFF,
    21'h01DC0, 21'h01DFF, 21'h020D0, 21'h020FF, 21'h0FE00, 21'h0FE0F, 21'h0FE20,
    21'h0FE2F, 21'hE0100, 21'hE01EF, 21'h01100, 21'h0115F, 21'h02329, 21'h0232A,
    21'h02E80, 21'h0A4CF, 21'h0AC00, 21'h0D7A3, 21'h0F900, 21'h0FAFF, 21'h0FE10,
    21'h0FE19, 21'h0FE30, 21'h0FE6F, 21'h0FF00, 21'h0FF60, 21'h0FFE0, 21'h0FFE6,
    21'h1F300, 21'h1F9FF, 21'h20000, 21'h3FFFD
  };

  utf8_display_width_counter u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .text_byte     (text_byte),
    .final_byte    (final_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .display_width (display_width)
  );

  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // Width model
  // --------------------------------------------------------------------------
  function automatic logic in_span(input logic [20:0] cp, input logic [20:0] lo,
                                   input logic [20:0] hi);
    return (cp >= lo) && (cp <= hi);
  endfunction

  function automatic int glyph_columns(input logic [20:0] cp);
    if (cp == 21'h0200B || cp == 21'h0200C || cp == 21'h0200D || cp == 21'h0FEFF ||
        in_span(cp, 21'h00300, 21'h0036F) || in_span(cp, 21'h01AB0, 21'h01AFF) ||
        in_span(cp, 21'h01DC0, 21'h01DFF) || in_span(cp, 21'h020D0, 21'h020FF) ||
        in_span(cp, 21'h0FE00, 21'h0FE0F) || in_span(cp, 21'h0FE20, 21'h0FE2F) ||
        in_span(cp, 21'hE0100, 21'hE01EF))
      return 0;
    if (in_span(cp, 21'h01100, 21'h0115F) || in_span(cp, 21'h02329, 21'h0232A) ||
        in_span(cp, 21'h02E80, 21'h0A4CF) || in_span(cp, 21'h0AC00, 21'h0D7A3) ||
        in_span(cp, 21'h0F900, 21'h0FAFF) || in_span(cp, 21'h0FE10, 21'h0FE19) ||
        in_span(cp, 21'h0FE30, 21'h0FE6F) || in_span(cp, 21'h0FF00, 21'h0FF60) ||
        in_span(cp, 21'h0FFE0, 21'h0FFE6) || in_span(cp, 21'h1F300, 21'h1F9FF) ||
        in_span(cp, 21'h20000, 21'h3FFFD))
      return 2;
    return 1;
  endfunction

  // Saturating add to the running total
  function automatic void add_cols(input int n);
    logic [16:0] sum;
    sum = {1'b0, col_total} + 17'(n);
    col_total = sum[16] ? 16'hFFFF : sum[15:0];
  endfunction

  function automatic void clear_text_state();
    held_cnt  = 2'd0;
    seq_need  = 3'd0;
    cp_acc    = 21'd0;
    col_total = 16'd0;
    stopped   = 1'b0;
  endfunction

  // A byte at a lead position: count it, open a sequence, or stop on a break
  function automatic void open_lead(input logic [7:0] b);
    if (stopped) return;
    if (b == u8dw_pkg::ByteLf || b == u8dw_pkg::ByteCr) begin
      stopped = 1'b1;
    end else if (b[7] == 1'b0) begin
      add_cols(glyph_columns(21'(b)));
    end else if (b[7:5] == 3'b110) begin
      seq_need = u8dw_pkg::SeqLen2;
      held_cnt = 2'd1;
      cp_acc   = 21'(b[4:0]);
    end else if (b[7:4] == 4'b1110) begin
      seq_need = u8dw_pkg::SeqLen3;
      held_cnt = 2'd1;
      cp_acc   = 21'(b[3:0]);
    end else if (b[7:3] == 5'b11110) begin
      seq_need = u8dw_pkg::SeqLen4;
      held_cnt = 2'd1;
      cp_acc   = 21'(b[2:0]);
    end else begin
      add_cols(glyph_columns(21'(b)));
    end
  endfunction

  // One accepted byte; gives the total when it is the final one
  function automatic void measure_byte(input logic [7:0] b, input logic fin,
                                       output logic has, output logic [15:0] width);
    int nxt;
    has   = 1'b0;
    width = 16'd0;
    if (stopped) begin
      // everything after a line break is ignored
    end else if (held_cnt != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        nxt    = int'(held_cnt) + 1;
        cp_acc = {cp_acc[14:0], b[5:0]};
        if (nxt >= int'(seq_need)) begin
          add_cols(glyph_columns(cp_acc));
          held_cnt = 2'd0;
        end else if (fin) begin
          add_cols(nxt);
          held_cnt = 2'd0;
        end else begin
          held_cnt = 2'(nxt);
        end
      end else begin
        // broken sequence: held bytes count one each, byte read afresh
        add_cols(int'(held_cnt));
        held_cnt = 2'd0;
        open_lead(b);
      end
    end else begin
      open_lead(b);
    end
    if (fin) begin
      if (held_cnt != 2'd0) add_cols(int'(held_cnt));
      has   = 1'b1;
      width = col_total;
      clear_text_state();
    end
  endfunction

  // --------------------------------------------------------------------------
  // Random string content
  // --------------------------------------------------------------------------
  // Append one byte to the string being built
  function automatic void queue_byte(input logic [7:0] b);
    str_q.insert(str_q.size(), b);
  endfunction

  function automatic void add_random_char();
    int          pick;
    int          need;
    int          n;
    int          keep;
    int          i;
    logic [20:0] cp;
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      queue_byte($urandom_range(0, 1) ? u8dw_pkg::ByteLf : u8dw_pkg::ByteCr);
      return;
    end
    if (pick <= 2) begin
      queue_byte(8'($urandom_range(0, 255)));
      return;
    end
    case (pick)
      3, 4, 5, 6, 7, 8: cp = 21'($urandom_range(32, 126));
      9, 10:            cp = 21'($urandom_range(0, 127));
      11, 12, 13:       cp = span_ends[$urandom_range(0, 38)] +
                             21'($urandom_range(0, 2)) - 21'd1;
      14:               cp = 21'($urandom_range(32'h80, 32'h7FF));
      15, 16, 19:       cp = 21'($urandom_range(32'h800, 32'hFFFF));
      17:               cp = 21'($urandom_range(32'h10000, 32'h3FFFF));
      default:          cp = 21'($urandom_range(32'h10000, 32'h1FFFFF));
    endcase
    need = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
    n = need;
    if ($urandom_range(0, 7) == 0) n = $urandom_range((need < 2) ? 2 : need, 4);
    keep = n;
    if (n > 1 && $urandom_range(0, 9) == 0) keep = $urandom_range(1, n - 1);
    // encode in n bytes, dropping the tail when truncated
    case (n)
      1:       queue_byte(cp[7:0]);
      2:       queue_byte({3'b110, cp[10:6]});
      3:       queue_byte({4'b1110, cp[15:12]});
      default: queue_byte({5'b11110, cp[20:18]});
    endcase
    for (i = n - 2; i > n - 1 - keep; i--) queue_byte({2'b10, cp[6*i +: 6]});
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b, input logic fin, input logic typed,
                           input logic [15:0] want);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    text_byte  <= b;
    final_byte <= fin;
    tag_typed  <= typed;
    tag_want   <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin : stimulus
    int i;
    int k;
    int sent;
    int nstr;
    int nchars;
    in_valid   = 1'b0;
    text_byte  = 8'd0;
    final_byte = 1'b0;
    tag_typed  = 1'b0;
    tag_want   = 16'd0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    hold_req   = 1'b0;
    errors     = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    for (i = 0; i < DirRows; i++) begin
      for (k = 0; k < int'(dir_tab[i].len); k++) begin
        push_byte(dir_tab[i].seq[47-8*k -: 8], k == int'(dir_tab[i].len) - 1,
                  dir_tab[i].typed, dir_tab[i].want);
      end
    end

    // Random strings
    sent = 0;
    nstr = 0;
    while (sent < RandomBytes) begin
      str_q.delete();
      nchars = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
      for (k = 0; k < nchars; k++) add_random_char();
      tx_idle_on = ($urandom_range(0, 3) != 0);
      if (nstr == 12) hold_req = 1'b1;
      for (k = 0; k < str_q.size(); k++) push_byte(str_q[k], k == str_q.size() - 1, 1'b0, 16'd0);
      sent += str_q.size();
      nstr++;
    end
    in_valid <= 1'b0;

    // Drain, then allow for the pipeline before the verdict
    while (pending_widths.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_widths.size() == 0) begin
      $display("utf8_display_width_counter: match");
    end else begin
      $display("utf8_display_width_counter: mismatch");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Output side: random stalls plus one long hold-off
  // --------------------------------------------------------------------------
  initial begin : receiver
    int gap;
    out_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end
      gap = rx_idle_on ? $urandom_range(0, 7) : 0;
      if ($urandom_range(0, 63) == 0) rx_idle_on = !rx_idle_on;
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: model each input transfer, check each output transfer
  // --------------------------------------------------------------------------
  function automatic void flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  always @(posedge clk) begin : monitor
    logic        has;
    logic [15:0] width;
    logic [15:0] due;
    if (rst) begin
      clear_text_state();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_widths.size() == 0) begin
          flag_error($sformatf("unexpected result: display_width=%0d", display_width));
        end else begin
          due = pending_widths.pop_front();
          if (display_width !== due) begin
            flag_error($sformatf("display_width: expected %0d, got %0d", due, display_width));
          end
        end
      end
      if (in_valid && in_ready) begin
        measure_byte(text_byte, final_byte, has, width);
        if (has) pending_widths.insert(pending_widths.size(), tag_typed ? tag_want : width);
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("utf8_display_width_counter: mismatch");
        $finish;
      end
    end
  end

endmodule
